/* hdl/tmw_pkg.sv */
// Shared types, widths and codes of the timing wheel sleep timer.
package tmw_pkg;

  // Field widths of the channels and of the entry store.
  localparam int ID_W    = 8;
  localparam int DELAY_W = 32;
  localparam int TICK_W  = 63;
  localparam int WAKE_W  = 64;
  localparam int ORDER_W = 32;

  // Default geometry.
  localparam int WHEEL_SLOTS_DEF = 32;
  localparam int MAX_TIMERS_DEF  = 16;

  // Request codes.
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_ADDED   = 3'd0,
    STAT_IGNORED = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_WOKEN   = 3'd3,
    STAT_NONE    = 3'd4
  } status_t;

endpackage

/* hdl/tmw_ifs.sv */
// Valid/ready channel interfaces for requests and results.
interface tmw_in_if;
  import tmw_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [ID_W-1:0]    sleeper_id;
  logic signed [DELAY_W-1:0] delay_ticks;
  modport source (output valid, func, sleeper_id, delay_ticks, input ready);
  modport sink   (input valid, func, sleeper_id, delay_ticks, output ready);
endinterface

interface tmw_out_if;
  import tmw_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [ID_W-1:0]   woken_id;
  logic [TICK_W-1:0] tick_count;
  logic              last;
  modport source (output valid, status, woken_id, tick_count, last, input ready);
  modport sink   (input valid, status, woken_id, tick_count, last, output ready);
endinterface

/* hdl/tmw_entry_mem.sv */
// Entry store: one write port and one registered read port.
module tmw_entry_mem #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 109,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/tmw_slot_unit.sv */
// Pipelined remainder unit that maps a delay and the hand to a wheel slot.
module tmw_slot_unit #(
  parameter int WHEEL_SLOTS = 32,
  parameter int SLOT_W      = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tmw_pkg::DELAY_W-2:0]     delay,
  input  logic [SLOT_W-1:0]               hand,
  output logic                            done,
  output logic [SLOT_W-1:0]               slot
);
  import tmw_pkg::*;

  localparam int BITS = DELAY_W - 1;
  // Reciprocal of the wheel size scaled by 2^BITS. The quotient it yields is the
  // true quotient or one below it, so one conditional subtract finishes the remainder.
  localparam logic [BITS-1:0]   RECIP = BITS'((64'd1 << BITS) / WHEEL_SLOTS);
  localparam logic [BITS-1:0]   W_B   = BITS'(WHEEL_SLOTS);
  localparam logic [SLOT_W:0]   W_R   = (SLOT_W+1)'(WHEEL_SLOTS);
  localparam logic [SLOT_W+1:0] W_X   = (SLOT_W+2)'(WHEEL_SLOTS);
  localparam logic [SLOT_W+1:0] W2_X  = (SLOT_W+2)'(2 * WHEEL_SLOTS);
  localparam logic [SLOT_W+1:0] WM1_X = (SLOT_W+2)'(WHEEL_SLOTS - 1);

  logic              s1_r;
  logic              s2_r;
  logic              s3_r;
  logic [BITS-1:0]   d_r;
  logic [2*BITS-1:0] prod_r;
  logic [SLOT_W:0]   rem2_r;
  logic              done_r;
  logic [SLOT_W-1:0] slot_r;

  logic [BITS-1:0]   quo;
  logic [BITS-1:0]   back;
  logic [BITS-1:0]   diff;
  logic [SLOT_W-1:0] rem;
  logic [SLOT_W+1:0] sum;
  logic [SLOT_W+1:0] sum_red;

  // Quotient estimate and the remainder before its final correction, below twice the size.
  always_comb begin
    quo  = prod_r[2*BITS-1:BITS];
    back = quo * W_B;
    diff = d_r - back;
  end

  // Final correction, then the slot is (remainder + hand - 1) modulo the wheel size.
  always_comb begin
    if (rem2_r >= W_R) begin
      rem = SLOT_W'(rem2_r - W_R);
    end else begin
      rem = rem2_r[SLOT_W-1:0];
    end
    sum = {2'b00, rem} + {2'b00, hand} + WM1_X;
    if (sum >= W2_X) begin
      sum_red = sum - W2_X;
    end else if (sum >= W_X) begin
      sum_red = sum - W_X;
    end else begin
      sum_red = sum;
    end
  end

  // Three stages: reciprocal multiply, multiply back and subtract, correct and add the hand.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      s3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      done_r <= s3_r;
      if (start) begin
        d_r <= delay;
      end
      if (s1_r) begin
        prod_r <= (2*BITS)'(d_r) * (2*BITS)'(RECIP);
      end
      if (s2_r) begin
        rem2_r <= diff[SLOT_W:0];
      end
      if (s3_r) begin
        slot_r <= sum_red[SLOT_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule

/* hdl/timing_wheel_sleep_timer_core.sv */
// Top level of the timing wheel sleep timer: control sequencer and entry state.
//
//   Channel  | Dir | Handshake     | Payload
//   in_ch    | in  | valid / ready | func, sleeper_id, delay_ticks
//   out_ch   | out | valid / ready | status, woken_id, tick_count, last
//
// An accepted add passes through the pipelined slot unit, then writes the entry, then
// loads the output register. An ignored or rejected add goes straight to the output
// register. A tick makes one full pass over the entry memory per woken sleeper plus one
// final pass, through its single read port. Reset is synchronous and clears the tick
// count, hand, insert sequence and entry valid bits at once. A new request is taken
// while the last result still waits in the output register; a stalled output
// holds the sequencer before its next result.
module timing_wheel_sleep_timer_core #(
  parameter int WHEEL_SLOTS = tmw_pkg::WHEEL_SLOTS_DEF,
  parameter int MAX_TIMERS  = tmw_pkg::MAX_TIMERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tmw_in_if.sink     in_ch,
  tmw_out_if.source  out_ch
);
  import tmw_pkg::*;

  localparam int SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
  localparam int DATA_W = SLOT_W + WAKE_W + ID_W + ORDER_W;
  localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(MAX_TIMERS);
  localparam logic [SLOT_W-1:0] HAND_TOP = SLOT_W'(WHEEL_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD_MOD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t               state_r;
  logic [TICK_W-1:0]    now_r;
  logic [SLOT_W-1:0]    hand_r;
  logic [ORDER_W-1:0]   seq_r;
  logic [MAX_TIMERS-1:0] valid_r;
  logic [DELAY_W-2:0]   d_r;
  logic [ID_W-1:0]      id_r;
  logic [IDX_W-1:0]     free_idx_r;
  logic [CNT_W-1:0]     scan_cnt_r;
  logic                 rd_pend_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 best_vld_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [WAKE_W-1:0]    best_wake_r;
  logic [ORDER_W-1:0]   best_age_r;
  logic [ID_W-1:0]      best_id_r;
  logic                 pend_vld_r;
  logic [ID_W-1:0]      pend_id_r;
  status_t              res_status_r;
  logic [ID_W-1:0]      res_id_r;
  logic                 res_last_r;
  logic                 ret_scan_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [ID_W-1:0]      out_id_r;
  logic [TICK_W-1:0]    out_tick_r;
  logic                 out_last_r;

  logic                 in_fire;
  logic                 add_ok;
  logic                 table_full;
  logic [IDX_W-1:0]     free_idx;
  logic                 slot_start;
  logic                 slot_done;
  logic [SLOT_W-1:0]    slot_val;
  logic                 wr_en;
  logic [DATA_W-1:0]    wr_data;
  logic                 rd_en;
  logic [DATA_W-1:0]    rd_data;
  logic [SLOT_W-1:0]    rd_slot;
  logic [WAKE_W-1:0]    rd_wake;
  logic [ID_W-1:0]      rd_id;
  logic [ORDER_W-1:0]   rd_order;
  logic [ORDER_W-1:0]   rd_age;
  logic                 hit;
  logic                 better;
  logic                 scan_end;
  logic                 out_free;

  // Request acceptance and add qualification.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign add_ok      = (in_ch.delay_ticks != '0) && !in_ch.delay_ticks[DELAY_W-1];
  assign table_full  = &valid_r;
  assign slot_start  = in_fire && (in_ch.func == FUNC_ADD) && add_ok && !table_full;

  // Lowest free entry.
  always_comb begin
    free_idx = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  tmw_slot_unit #(
    .WHEEL_SLOTS (WHEEL_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_slot (
    .clk   (clk),
    .rst_n (rst_n),
    .start (slot_start),
    .delay (in_ch.delay_ticks[DELAY_W-2:0]),
    .hand  (hand_r),
    .done  (slot_done),
    .slot  (slot_val)
  );

  // Entry write when the slot is known.
  assign wr_en   = (state_r == ST_ADD_MOD) && slot_done;
  assign wr_data = {slot_val, {1'b0, now_r} + {{(WAKE_W-DELAY_W+1){1'b0}}, d_r}, id_r, seq_r};

  // Scan reads entries in index order.
  assign rd_en = (state_r == ST_SCAN) && (scan_cnt_r < CNT_END);

  tmw_entry_mem #(
    .DEPTH  (MAX_TIMERS),
    .DATA_W (DATA_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign {rd_slot, rd_wake, rd_id, rd_order} = rd_data;
  assign rd_age = seq_r - rd_order;

  // Due entry in the slot under the hand, and whether it outranks the best so far.
  assign hit = rd_pend_r && valid_r[rd_idx_r] && (rd_slot == hand_r) &&
               (rd_wake <= {1'b0, now_r});
  assign better = !best_vld_r || (rd_wake < best_wake_r) ||
                  ((rd_wake == best_wake_r) && (rd_age > best_age_r));
  assign scan_end = (state_r == ST_SCAN) && (scan_cnt_r == CNT_END) && !rd_pend_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer, entry state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      hand_r      <= '0;
      seq_r       <= '0;
      valid_r     <= '0;
      rd_pend_r   <= 1'b0;
      best_vld_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      rd_pend_r <= rd_en;
      rd_idx_r  <= scan_cnt_r[IDX_W-1:0];
      if (rd_en) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      if (hit && better) begin
        best_vld_r  <= 1'b1;
        best_idx_r  <= rd_idx_r;
        best_wake_r <= rd_wake;
        best_age_r  <= rd_age;
        best_id_r   <= rd_id;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            d_r        <= in_ch.delay_ticks[DELAY_W-2:0];
            id_r       <= in_ch.sleeper_id;
            free_idx_r <= free_idx;
            res_id_r   <= '0;
            res_last_r <= 1'b1;
            ret_scan_r <= 1'b0;
            if (in_ch.func == FUNC_TICK) begin
              now_r      <= now_r + 1'b1;
              scan_cnt_r <= '0;
              best_vld_r <= 1'b0;
              pend_vld_r <= 1'b0;
              state_r    <= ST_SCAN;
            end else if (!add_ok) begin
              res_status_r <= STAT_IGNORED;
              state_r      <= ST_EMIT;
            end else if (table_full) begin
              res_status_r <= STAT_FULL;
              state_r      <= ST_EMIT;
            end else begin
              state_r <= ST_ADD_MOD;
            end
          end
        end
        ST_ADD_MOD: begin
          if (slot_done) begin
            valid_r[free_idx_r] <= 1'b1;
            seq_r               <= seq_r + 1'b1;
            res_status_r        <= STAT_ADDED;
            state_r             <= ST_EMIT;
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            if (best_vld_r) begin
              valid_r[best_idx_r] <= 1'b0;
              pend_vld_r          <= 1'b1;
              pend_id_r           <= best_id_r;
              best_vld_r          <= 1'b0;
              if (pend_vld_r) begin
                // The earlier sleeper is not the final one of this tick.
                res_status_r <= STAT_WOKEN;
                res_id_r     <= pend_id_r;
                res_last_r   <= 1'b0;
                ret_scan_r   <= 1'b1;
                state_r      <= ST_EMIT;
              end else begin
                scan_cnt_r <= '0;
              end
            end else begin
              res_status_r <= pend_vld_r ? STAT_WOKEN : STAT_NONE;
              res_id_r     <= pend_vld_r ? pend_id_r : '0;
              res_last_r   <= 1'b1;
              ret_scan_r   <= 1'b0;
              pend_vld_r   <= 1'b0;
              hand_r       <= (hand_r == HAND_TOP) ? '0 : hand_r + 1'b1;
              state_r      <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_id_r     <= res_id_r;
            out_tick_r   <= now_r;
            out_last_r   <= res_last_r;
            if (ret_scan_r) begin
              scan_cnt_r <= '0;
              best_vld_r <= 1'b0;
              state_r    <= ST_SCAN;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.woken_id   = out_id_r;
  assign out_ch.tick_count = out_tick_r;
  assign out_ch.last       = out_last_r;

  // A new entry is only ever written into a free place.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !valid_r[free_idx_r])
    else $error("entry write hits a live entry");

  // The written entry becomes live in the next cycle.
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(free_idx_r)])
    else $error("written entry not marked valid");

  // A woken sleeper leaves the table when its scan ends.
  a_wake_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_end && best_vld_r) |=> !valid_r[$past(best_idx_r)])
    else $error("woken entry still valid");

  // Scan reads never go past the table.
  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (scan_cnt_r < CNT_END))
    else $error("entry read beyond table");

  // Only a woken sleeper may be followed by more results of the same request.
  a_not_last_woken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r == STAT_WOKEN))
    else $error("non-final result that is not a wake");

endmodule

/* tb/tb_timing_wheel_sleep_timer_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the timing wheel sleep timer core with its own wheel predictor.
module tb_timing_wheel_sleep_timer_core;
  import tmw_pkg::*;

  localparam int WHEEL_SLOTS = WHEEL_SLOTS_DEF;
  localparam int MAX_TIMERS  = MAX_TIMERS_DEF;
  // Longest run of cycles without any accepted transaction before the run is abandoned.
  localparam int STALL_LIMIT = 4000;
  // Quiet time after the last expected result, to catch spurious extra results.
  localparam int TAIL_CYCLES = 600;

  typedef struct {
    logic               func;
    logic [ID_W-1:0]    sleeper_id;
    logic [DELAY_W-1:0] delay_ticks;
  } sleep_req_t;

  typedef struct {
    status_t           status;
    logic [ID_W-1:0]   woken_id;
    logic [TICK_W-1:0] tick_count;
    logic              last;
  } wake_result_t;

  logic clk;
  logic rst_n;

  tmw_in_if  in_ch ();
  tmw_out_if out_ch ();

  timing_wheel_sleep_timer_core #(
    .WHEEL_SLOTS(WHEEL_SLOTS),
    .MAX_TIMERS (MAX_TIMERS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Predicted wheel state.
  logic [TICK_W-1:0]  now_ticks;
  int                 hand;
  logic [ORDER_W-1:0] add_seq;
  logic               ent_valid [MAX_TIMERS];
  int                 ent_slot  [MAX_TIMERS];
  logic [WAKE_W-1:0]  ent_wake  [MAX_TIMERS];
  logic [ID_W-1:0]    ent_id    [MAX_TIMERS];
  logic [ORDER_W-1:0] ent_order [MAX_TIMERS];

  sleep_req_t   request_q[$];
  wake_result_t expected_wakes[$];

  int   src_idle_pct;
  int   sink_stall_pct;
  int   err_count;
  int   idle_cycles;
  logic in_taken;

  always #2 clk = ~clk;

  // Apply one accepted request to the predicted wheel and queue the results it causes.
  task automatic advance_wheel(input logic func, input logic [ID_W-1:0] id,
                               input logic [DELAY_W-1:0] delay);
    int free_idx;
    int best;
    int woken;
    logic [ORDER_W-1:0] age_i;
    logic [ORDER_W-1:0] age_b;
    wake_result_t res;
    wake_result_t held;
    res.woken_id = '0;
    res.last     = 1'b1;
    if (func == FUNC_ADD) begin
      // The lowest free entry takes the new sleeper.
      free_idx = -1;
      for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
        if (!ent_valid[i]) free_idx = i;
      end
      if (delay == '0 || delay[DELAY_W-1]) begin
        res.status = STAT_IGNORED;
      end else if (free_idx < 0) begin
        res.status = STAT_FULL;
      end else begin
        ent_valid[free_idx] = 1'b1;
        ent_slot[free_idx]  = (delay % WHEEL_SLOTS + hand + WHEEL_SLOTS - 1) % WHEEL_SLOTS;
        ent_wake[free_idx]  = {1'b0, now_ticks} + {{(WAKE_W-DELAY_W){1'b0}}, delay};
        ent_id[free_idx]    = id;
        ent_order[free_idx] = add_seq;
        add_seq             = add_seq + 1'b1;
        res.status          = STAT_ADDED;
      end
      res.tick_count = now_ticks;
      expected_wakes.push_back(res);
    end else begin
      now_ticks = now_ticks + 1'b1;
      woken     = 0;
      // Wake due sleepers in the slot under the hand: earliest wake time first, then oldest.
      do begin
        best = -1;
        for (int i = 0; i < MAX_TIMERS; i++) begin
          if (ent_valid[i] && ent_slot[i] == hand && ent_wake[i] <= {1'b0, now_ticks}) begin
            if (best < 0) begin
              best = i;
            end else if (ent_wake[i] != ent_wake[best]) begin
              if (ent_wake[i] < ent_wake[best]) best = i;
            end else begin
              age_i = add_seq - ent_order[i];
              age_b = add_seq - ent_order[best];
              if (age_i > age_b) best = i;
            end
          end
        end
        if (best >= 0) begin
          ent_valid[best] = 1'b0;
          if (woken > 0) expected_wakes.push_back(held);
          held.status     = STAT_WOKEN;
          held.woken_id   = ent_id[best];
          held.tick_count = now_ticks;
          held.last       = 1'b0;
          woken++;
        end
      end while (best >= 0);
      if (woken == 0) begin
        res.status     = STAT_NONE;
        res.tick_count = now_ticks;
        expected_wakes.push_back(res);
      end else begin
        held.last = 1'b1;
        expected_wakes.push_back(held);
      end
      hand = (hand + 1) % WHEEL_SLOTS;
    end
  endtask

  task automatic enqueue_request(input logic func, input logic [ID_W-1:0] id,
                                 input logic [DELAY_W-1:0] delay);
    sleep_req_t req;
    req.func        = func;
    req.sleeper_id  = id;
    req.delay_ticks = delay;
    request_q.push_back(req);
  endtask

  // Hold off until every queued request is accepted and every expected result has arrived.
  task automatic wait_drained();
    while (request_q.size() != 0 || in_ch.valid || expected_wakes.size() != 0)
      @(posedge clk);
  endtask

  // One random phase: mostly ticks and short sleeps, with some long, ignored and raw delays.
  task automatic run_random_phase(input int src_pct, input int sink_pct, input int count);
    int pick;
    logic [DELAY_W-1:0] delay;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 48) begin
        enqueue_request(FUNC_TICK, ID_W'($urandom_range(255)), $urandom);
      end else begin
        pick = $urandom_range(99);
        if (pick < 80) delay = $urandom_range(40, 1);
        else if (pick < 90) delay = $urandom_range(200, 41);
        else if (pick < 95) delay = 32'd0 - 32'($urandom_range(3));
        else delay = $urandom;
        enqueue_request(FUNC_ADD, ID_W'($urandom_range(255)), delay);
      end
    end
    wait_drained();
  endtask

  // Request driver: presents the next transaction once the current one has been taken.
  always @(negedge clk) begin : drive
    sleep_req_t req;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (request_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        req = request_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.func        <= req.func;
        in_ch.sleeper_id  <= req.sleeper_id;
        in_ch.delay_ticks <= req.delay_ticks;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: predicts on accepted requests and checks every accepted result.
  always @(posedge clk) begin : monitor
    wake_result_t got;
    wake_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        advance_wheel(in_ch.func, in_ch.sleeper_id, in_ch.delay_ticks);
      if (out_ch.valid && out_ch.ready) begin
        got.status     = out_ch.status;
        got.woken_id   = out_ch.woken_id;
        got.tick_count = out_ch.tick_count;
        got.last       = out_ch.last;
        if (expected_wakes.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d id %0h tick %0d last %0b",
                   $time, got.status, got.woken_id, got.tick_count, got.last);
          err_count++;
        end else begin
          want = expected_wakes.pop_front();
          if (got.status !== want.status || got.woken_id !== want.woken_id ||
              got.tick_count !== want.tick_count || got.last !== want.last) begin
            $display("%0t: mismatch: expected status %0d id %0h tick %0d last %0b", $time,
                     want.status, want.woken_id, want.tick_count, want.last);
            $display("%0t:           got      status %0d id %0h tick %0d last %0b", $time,
                     got.status, got.woken_id, got.tick_count, got.last);
            err_count++;
          end
        end
      end
      in_taken    <= in_ch.valid && in_ch.ready;
      idle_cycles <= ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) ?
                     0 : idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any accepted transaction.
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL timing_wheel_sleep_timer_core");
    $finish;
  end

  initial begin : stimulus
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_ADD;
    in_ch.sleeper_id  = '0;
    in_ch.delay_ticks = '0;
    out_ch.ready      = 1'b0;
    in_taken          = 1'b0;
    idle_cycles       = 0;
    err_count         = 0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    now_ticks         = '0;
    hand              = 0;
    add_seq           = '0;
    for (int i = 0; i < MAX_TIMERS; i++) ent_valid[i] = 1'b0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, non-positive delays, the largest delay, a tie and a later lap.
    enqueue_request(FUNC_TICK, 8'h00, 32'h0000_0000);
    enqueue_request(FUNC_ADD, 8'h00, 32'h0000_0000);
    enqueue_request(FUNC_ADD, 8'hFF, 32'hFFFF_FFFF);
    enqueue_request(FUNC_ADD, 8'hAA, 32'h8000_0000);
    enqueue_request(FUNC_ADD, 8'h55, 32'h7FFF_FFFF);
    enqueue_request(FUNC_ADD, 8'h01, 32'd1);
    enqueue_request(FUNC_ADD, 8'h02, 32'd1);
    enqueue_request(FUNC_ADD, 8'h03, 32'd33);
    enqueue_request(FUNC_TICK, 8'hFF, 32'hFFFF_FFFF);
    // Fill the table, then one add that finds it full.
    for (int i = 0; i < 14; i++)
      enqueue_request(FUNC_ADD, ID_W'(8'h10 + i), 32'(i + 2));
    enqueue_request(FUNC_ADD, 8'hFE, 32'd5);
    enqueue_request(FUNC_TICK, 8'h00, 32'h0000_0000);
    wait_drained();

    // Random phases with different idle and stall patterns.
    run_random_phase(0, 0, 118);
    run_random_phase(75, 0, 118);
    run_random_phase(0, 75, 117);
    run_random_phase(22, 22, 117);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_wakes.size() == 0) begin
      $display("PASS timing_wheel_sleep_timer_core");
    end else begin
      $display("FAIL timing_wheel_sleep_timer_core");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tmw_pkg.sv
hdl/tmw_ifs.sv
hdl/tmw_entry_mem.sv
hdl/tmw_slot_unit.sv
hdl/timing_wheel_sleep_timer_core.sv
tb/tb_timing_wheel_sleep_timer_core.sv
